// ===== src/spcr_pkg.sv =====
package spcr_pkg;

    // field widths
    localparam int VEC_W     = 32;
    localparam int RAD_W     = 31;
    localparam int DAMP_W    = 17;
    localparam int DAMP_BITS = 16;

    // stream payload widths
    localparam int S_DATA_W = 352;
    localparam int M_DATA_W = 192;

    // divider widths: numerator 2*|s|*|d|*damp + half, denominator d.d << 16
    localparam int NUM_W   = 114;
    localparam int DEN_W   = 80;
    localparam int QUO_W   = 41;
    localparam int DIV_LAT = QUO_W + 1;

    // largest correction magnitude, 2^40
    localparam logic [QUO_W-1:0] TERM_LIMIT = {1'b1, {(QUO_W-1){1'b0}}};

    // register reset values
    localparam logic [DAMP_W-1:0] DAMP_NORMAL_RST = 17'd65012;
    localparam logic [DAMP_W-1:0] DAMP_LOSE_RST   = 17'd62259;

    // register indexes
    typedef enum logic [0:0] {
        REG_DAMP_NORMAL = 1'b0,
        REG_DAMP_LOSE   = 1'b1
    } t_reg_idx;

endpackage

// ===== src/spcr_div.sv =====
module spcr_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [spcr_pkg::NUM_W-1:0]  i_num,
    input  logic [spcr_pkg::DEN_W-1:0]  i_den,
    output logic [spcr_pkg::QUO_W-1:0]  o_quo
);

    localparam int QB = spcr_pkg::QUO_W;
    localparam int DW = spcr_pkg::DEN_W;
    localparam int NW = spcr_pkg::NUM_W;

    logic [DW-1:0] r_rem [0:QB];
    logic [DW-1:0] r_den [0:QB];
    logic [QB-1:0] r_nlo [0:QB];
    logic [QB-1:0] r_q   [0:QB];
    logic          r_ovf [0:QB];

    logic [NW-QB-1:0] w_top;
    logic             w_ovf;
    logic [DW:0]      w_try  [0:QB-1];
    logic [DW:0]      w_diff [0:QB-1];
    logic             w_ge   [0:QB-1];

    // quotient overflows its bits when the top part already reaches the divisor
    assign w_top = i_num[NW-1:QB];
    assign w_ovf = DW'(w_top) >= i_den;

    // one restoring step per stage
    always_comb begin
        for (int k = 0; k < QB; k++) begin
            w_try[k]  = {r_rem[k], r_nlo[k][QB-1]};
            w_ge[k]   = w_try[k] >= {1'b0, r_den[k]};
            w_diff[k] = w_try[k] - {1'b0, r_den[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DW'(w_top);
            r_den[0] <= i_den;
            r_nlo[0] <= i_num[QB-1:0];
            r_q[0]   <= '0;
            r_ovf[0] <= w_ovf;
            for (int k = 0; k < QB; k++) begin
                r_rem[k+1] <= w_ge[k] ? w_diff[k][DW-1:0] : w_try[k][DW-1:0];
                r_den[k+1] <= r_den[k];
                r_nlo[k+1] <= {r_nlo[k][QB-2:0], 1'b0};
                r_q[k+1]   <= {r_q[k][QB-2:0], w_ge[k]};
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    // clamp the correction magnitude
    assign o_quo = (r_ovf[QB] || (r_q[QB] > spcr_pkg::TERM_LIMIT)) ?
                   spcr_pkg::TERM_LIMIT : r_q[QB];

endmodule

// ===== src/sphere_pair_collide_reflect.sv =====
// sphere pair collision response
//
// slave stream: one sphere pair per request; tdata holds diff xyz, vel_a xyz,
// vel_b xyz (32 bits each), radius_a, radius_b (31 bits each), low bit first;
// tuser holds lose_flag. master stream: one result per pair; tdata holds
// new_a xyz then new_b xyz, tuser holds colliding.
// config port: i_cfg_we writes i_cfg_wdata into damp_normal (index 0) or
// damp_lose (index 1), unsigned Q1.16; the user must write only while the
// block is idle, which the block itself does not enforce.
// throughput: one pair per cycle while o_s_axis_tready is high. a pair passes
// 7 arithmetic stages, the 42-stage restoring divider for the correction
// (one quotient bit per stage, six dividers in parallel) and the output
// buffer write before tvalid.
// the result lands in a two-entry output buffer; when the receiver stalls,
// o_s_axis_tready falls only once both entries are full, then the whole
// pipeline holds and nothing is lost.
// reset (synchronous, active low) empties the pipeline and buffer and loads
// the damping registers with 0.992 and 0.95.
module sphere_pair_collide_reflect (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // diff_x, diff_y, diff_z, vel_a_x..z, vel_b_x..z, radius_a, radius_b, pad
    input  logic [spcr_pkg::S_DATA_W-1:0]  i_s_axis_tdata,
    // lose_flag
    input  logic [0:0]                     i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // new_a_x, new_a_y, new_a_z, new_b_x, new_b_y, new_b_z
    output logic [spcr_pkg::M_DATA_W-1:0]  o_m_axis_tdata,
    // colliding
    output logic [0:0]                     o_m_axis_tuser,
    input  logic                           i_cfg_we,
    input  logic [0:0]                     i_cfg_idx,
    input  logic [spcr_pkg::DAMP_W-1:0]    i_cfg_wdata
);

    localparam int VW  = spcr_pkg::VEC_W;
    localparam int RW  = spcr_pkg::RAD_W;
    localparam int LAT = spcr_pkg::DIV_LAT;

    typedef struct packed {
        logic               hit;
        logic [5:0]         neg;
        logic [2:0][31:0]   va;
        logic [2:0][31:0]   vb;
    } t_side;

    typedef struct packed {
        logic                          coll;
        logic [spcr_pkg::M_DATA_W-1:0] data;
    } t_out;

    // configuration registers
    logic [spcr_pkg::DAMP_W-1:0] r_damp_normal, r_damp_lose;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damp_normal <= spcr_pkg::DAMP_NORMAL_RST;
            r_damp_lose   <= spcr_pkg::DAMP_LOSE_RST;
        end else if (i_cfg_we) begin
            unique case (spcr_pkg::t_reg_idx'(i_cfg_idx))
                spcr_pkg::REG_DAMP_NORMAL: r_damp_normal <= i_cfg_wdata;
                spcr_pkg::REG_DAMP_LOSE:   r_damp_lose   <= i_cfg_wdata;
            endcase
        end
    end

    // pipeline advance: output buffer has room
    logic [1:0] r_cnt;
    logic       w_en, w_acc;

    assign w_en            = (r_cnt != 2'd2);
    assign o_s_axis_tready = w_en;
    assign w_acc           = i_s_axis_tvalid & w_en;

    // stage 1: register request, pick damping
    logic                        r_v1;
    logic signed [VW-1:0]        r_s1_d  [3];
    logic signed [VW-1:0]        r_s1_va [3];
    logic signed [VW-1:0]        r_s1_vb [3];
    logic [RW-1:0]               r_s1_ra, r_s1_rb;
    logic [spcr_pkg::DAMP_W-1:0] r_s1_damp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s1_d[i]  <= i_s_axis_tdata[VW*i +: VW];
                r_s1_va[i] <= i_s_axis_tdata[VW*(3+i) +: VW];
                r_s1_vb[i] <= i_s_axis_tdata[VW*(6+i) +: VW];
            end
            r_s1_ra   <= i_s_axis_tdata[VW*9 +: RW];
            r_s1_rb   <= i_s_axis_tdata[VW*9+RW +: RW];
            r_s1_damp <= i_s_axis_tuser[0] ? r_damp_lose : r_damp_normal;
        end
    end

    // stage 2: products
    logic signed [63:0] w_sq [3];
    logic signed [63:0] w_pa [3];
    logic signed [63:0] w_pb [3];
    logic [VW-1:0]      w_dmag [3];
    logic [48:0]        w_dm [3];
    logic [VW-1:0]      w_rsum;
    logic [63:0]        w_rr;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sq[i]   = r_s1_d[i] * r_s1_d[i];
            w_pa[i]   = r_s1_va[i] * r_s1_d[i];
            w_pb[i]   = r_s1_vb[i] * r_s1_d[i];
            w_dmag[i] = r_s1_d[i][VW-1] ? (~r_s1_d[i] + 32'd1) : r_s1_d[i];
            w_dm[i]   = w_dmag[i] * r_s1_damp;
        end
        w_rsum = {1'b0, r_s1_ra} + {1'b0, r_s1_rb};
        w_rr   = w_rsum * w_rsum;
    end

    logic               r_v2;
    logic [62:0]        r_s2_sq [3];
    logic signed [63:0] r_s2_pa [3];
    logic signed [63:0] r_s2_pb [3];
    logic [47:0]        r_s2_dm [3];
    logic [63:0]        r_s2_rr;
    logic [2:0]         r_s2_dneg;
    logic [2:0][31:0]   r_s2_va, r_s2_vb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s2_sq[i]   <= w_sq[i][62:0];
                r_s2_pa[i]   <= w_pa[i];
                r_s2_pb[i]   <= w_pb[i];
                r_s2_dm[i]   <= w_dm[i][47:0];
                r_s2_dneg[i] <= r_s1_d[i][VW-1];
                r_s2_va[i]   <= r_s1_va[i];
                r_s2_vb[i]   <= r_s1_vb[i];
            end
            r_s2_rr <= w_rr;
        end
    end

    // stage 3: dot products
    logic               r_v3;
    logic [63:0]        r_s3_dd;
    logic signed [65:0] r_s3_sa, r_s3_sb;
    logic [63:0]        r_s3_rr;
    logic [47:0]        r_s3_dm [3];
    logic [2:0]         r_s3_dneg;
    logic [2:0][31:0]   r_s3_va, r_s3_vb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_dd   <= {1'b0, r_s2_sq[0]} + {1'b0, r_s2_sq[1]} + {1'b0, r_s2_sq[2]};
            r_s3_sa   <= 66'(r_s2_pa[0]) + 66'(r_s2_pa[1]) + 66'(r_s2_pa[2]);
            r_s3_sb   <= 66'(r_s2_pb[0]) + 66'(r_s2_pb[1]) + 66'(r_s2_pb[2]);
            r_s3_rr   <= r_s2_rr;
            r_s3_dm   <= r_s2_dm;
            r_s3_dneg <= r_s2_dneg;
            r_s3_va   <= r_s2_va;
            r_s3_vb   <= r_s2_vb;
        end
    end

    // stage 4: collision test, magnitudes and correction signs
    logic signed [66:0] w_rel;
    logic               w_hit, w_nega, w_negb;

    assign w_rel  = 67'(r_s3_sa) - 67'(r_s3_sb);
    assign w_hit  = (r_s3_rr >= r_s3_dd) && w_rel[66] && (r_s3_dd != 64'd0);
    assign w_nega = r_s3_sa[65];
    assign w_negb = r_s3_sb[65];

    logic        r_v4;
    t_side       r_s4_side;
    logic [63:0] r_s4_smag_a, r_s4_smag_b, r_s4_dd;
    logic [47:0] r_s4_dm [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_side.hit <= w_hit;
            for (int i = 0; i < 3; i++) begin
                r_s4_side.neg[i]   <= w_nega ^ r_s3_dneg[i];
                r_s4_side.neg[i+3] <= w_negb ^ r_s3_dneg[i];
            end
            r_s4_side.va <= r_s3_va;
            r_s4_side.vb <= r_s3_vb;
            r_s4_smag_a  <= w_nega ? (~r_s3_sa[63:0] + 64'd1) : r_s3_sa[63:0];
            r_s4_smag_b  <= w_negb ? (~r_s3_sb[63:0] + 64'd1) : r_s3_sb[63:0];
            r_s4_dd      <= r_s3_dd;
            r_s4_dm      <= r_s3_dm;
        end
    end

    // stage 5: partial products of |s| * |d| * damp, six components
    logic [55:0] w_pp [6][4];
    logic [63:0] w_sm [6];
    logic [47:0] w_mm [6];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sm[i]   = r_s4_smag_a;
            w_sm[i+3] = r_s4_smag_b;
            w_mm[i]   = r_s4_dm[i];
            w_mm[i+3] = r_s4_dm[i];
        end
        for (int j = 0; j < 6; j++) begin
            w_pp[j][0] = w_sm[j][31:0]  * w_mm[j][23:0];
            w_pp[j][1] = w_sm[j][31:0]  * w_mm[j][47:24];
            w_pp[j][2] = w_sm[j][63:32] * w_mm[j][23:0];
            w_pp[j][3] = w_sm[j][63:32] * w_mm[j][47:24];
        end
    end

    logic        r_v5;
    t_side       r_s5_side;
    logic [55:0] r_s5_pp [6][4];
    logic [63:0] r_s5_dd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_side <= r_s4_side;
            r_s5_pp   <= w_pp;
            r_s5_dd   <= r_s4_dd;
        end
    end

    // stage 6: partial sums
    logic        r_v6;
    t_side       r_s6_side;
    logic [80:0] r_s6_t0 [6];
    logic [80:0] r_s6_t1 [6];
    logic [63:0] r_s6_dd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (w_en) begin
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 6; j++) begin
                r_s6_t0[j] <= 81'(r_s5_pp[j][0]) + (81'(r_s5_pp[j][1]) << 24);
                r_s6_t1[j] <= 81'(r_s5_pp[j][2]) + (81'(r_s5_pp[j][3]) << 24);
            end
            r_s6_side <= r_s5_side;
            r_s6_dd   <= r_s5_dd;
        end
    end

    // stage 7: doubled numerator plus half divisor for rounding
    logic                         r_v7;
    t_side                        r_s7_side;
    logic [spcr_pkg::NUM_W-1:0]   r_s7_num [6];
    logic [spcr_pkg::DEN_W-1:0]   r_s7_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
        end else if (w_en) begin
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 6; j++) begin
                r_s7_num[j] <= ((spcr_pkg::NUM_W'(r_s6_t0[j]) +
                                (spcr_pkg::NUM_W'(r_s6_t1[j]) << 32)) << 1) +
                               (spcr_pkg::NUM_W'(r_s6_dd) << (spcr_pkg::DAMP_BITS - 1));
            end
            r_s7_den  <= {r_s6_dd, {spcr_pkg::DAMP_BITS{1'b0}}};
            r_s7_side <= r_s6_side;
        end
    end

    // dividers, one per velocity component
    logic [spcr_pkg::QUO_W-1:0] w_quo [6];

    for (genvar g = 0; g < 6; g++) begin : g_div
        spcr_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_s7_num[g]),
            .i_den (r_s7_den),
            .o_quo (w_quo[g])
        );
    end

    // side data delay matching the divider
    logic  r_dvld  [0:LAT-1];
    t_side r_dside [0:LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_dvld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_dvld[0] <= r_v7;
            for (int k = 1; k < LAT; k++) begin
                r_dvld[k] <= r_dvld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dside[0] <= r_s7_side;
            for (int k = 1; k < LAT; k++) begin
                r_dside[k] <= r_dside[k-1];
            end
        end
    end

    // apply correction with saturation
    t_side              w_fs;
    logic signed [VW-1:0] w_v   [6];
    logic signed [42:0]   w_sum [6];
    logic [VW-1:0]        w_res [6];
    t_out                 w_out;

    assign w_fs = r_dside[LAT-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_v[i]   = w_fs.va[i];
            w_v[i+3] = w_fs.vb[i];
        end
        for (int j = 0; j < 6; j++) begin
            if (w_fs.neg[j]) begin
                w_sum[j] = 43'(w_v[j]) + $signed({2'b00, w_quo[j]});
            end else begin
                w_sum[j] = 43'(w_v[j]) - $signed({2'b00, w_quo[j]});
            end
            if (!w_fs.hit) begin
                w_res[j] = w_v[j];
            end else if (w_sum[j] > 43'sd2147483647) begin
                w_res[j] = 32'h7fff_ffff;
            end else if (w_sum[j] < -43'sd2147483648) begin
                w_res[j] = 32'h8000_0000;
            end else begin
                w_res[j] = w_sum[j][VW-1:0];
            end
        end
        w_out.coll = w_fs.hit;
        for (int j = 0; j < 6; j++) begin
            w_out.data[VW*j +: VW] = w_res[j];
        end
    end

    // two-entry output buffer
    t_out r_buf [2];
    logic r_wp, r_rp;
    logic w_push, w_pop;

    assign w_push = w_en & r_dvld[LAT-1];
    assign w_pop  = o_m_axis_tvalid & i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= w_out;
        end
    end

    assign o_m_axis_tvalid   = (r_cnt != 2'd0);
    assign o_m_axis_tdata    = r_buf[r_rp].data;
    assign o_m_axis_tuser[0] = r_buf[r_rp].coll;

endmodule

// ===== src/spcr_chk.sv =====
module spcr_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic [spcr_pkg::S_DATA_W-1:0]  i_s_axis_tdata,
    input logic [0:0]                     i_s_axis_tuser,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [spcr_pkg::M_DATA_W-1:0]  o_m_axis_tdata,
    input logic [0:0]                     o_m_axis_tuser,
    input logic                           i_cfg_we,
    input logic [0:0]                     i_cfg_idx,
    input logic [spcr_pkg::DAMP_W-1:0]    i_cfg_wdata
);

    // reset empties the output side
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // input only stalls while results wait
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with empty output");

    // a taken result always frees room for a request
    a_pop_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready |=> o_s_axis_tready)
        else $error("no room after result taken");

endmodule

bind sphere_pair_collide_reflect spcr_chk u_spcr_chk (.*);
